/* sv/fwtc_pkg.sv */
package fwtc_pkg;

   localparam int TIME_W   = 48;
   localparam int TENANT_W = 4;
   localparam int ENTITY_W = 6;
   localparam int TAG_W    = 6;
   localparam int LEN_W    = 32;
   localparam int COUNT_W  = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int WIDE_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD     = 2'd2;

   localparam logic [1:0] GROUP_ENTITY = 2'd0;
   localparam logic [1:0] GROUP_TENANT = 2'd1;
   localparam logic [1:0] GROUP_TAG    = 2'd2;

   localparam logic [1:0]         GROUP_MODE_RESET = GROUP_ENTITY;
   localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RESET = 32'd60000;
   localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 32'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [TIME_W-1:0]  window;
      logic [COUNT_W-1:0] count;
   } fwtc_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_MERGE,
      ST_FINISH
   } fwtc_state_type;

endpackage

/* sv/fwtc_divider.sv */
module fwtc_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fwtc_pkg::TIME_W-1:0]     dividend,
   input  logic [fwtc_pkg::LEN_W-1:0]      divisor,
   output logic                            done,
   output logic [fwtc_pkg::TIME_W-1:0]     quotient
);
   import fwtc_pkg::*;

   localparam int STEP_W = $clog2(TIME_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

   // restoring divider, one quotient bit per cycle
   logic [TIME_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              zero_ff, zero_in;
   logic [LEN_W:0]    trial;
   logic [LEN_W:0]    diff;

   assign trial = {rem_ff, quo_ff[TIME_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         zero_in = (divisor == '0);
         step_in = LAST_STEP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[LEN_W]) begin
            rem_in = diff[LEN_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b1};
         end else begin
            rem_in = trial[LEN_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   // zero length: everything lands in window 0
   assign quotient = zero_ff ? '0 : quo_ff;

endmodule

/* sv/fwtc_table.sv */
module fwtc_table #(
   parameter int ADDR_BITS = 10
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [ADDR_BITS-1:0]           rd_addr,
   output fwtc_pkg::fwtc_entry_type       rd_data,
   input  logic                           wr_en,
   input  logic [ADDR_BITS-1:0]           wr_addr,
   input  fwtc_pkg::fwtc_entry_type       wr_data
);
   import fwtc_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   fwtc_entry_type table_ff [DEPTH];
   fwtc_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/fixed_window_threshold_counter_core.sv */
// Flow: an accepted req beat starts the bit-serial 48/32 window divider (48 steps);
//   then divider done, merge and commit follow, and rsp_valid is registered at commit.
// Issue: a new req beat is taken only after the last one is committed, and commit
//   waits while rsp stalls; req_ready is high only while the sequencer idles.
// Reset: synchronous, active high; state and config registers return to their reset
//   values and a clearing pass over 2**(TENANT_BITS+KEY_BITS) entries (1024 by default)
//   zeroes the window table before the first req beat is taken.
module fixed_window_threshold_counter_core #(
   parameter int TENANT_BITS = 4,
   parameter int KEY_BITS    = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // config
   input  logic                              csr_wr_en,
   input  logic [fwtc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fwtc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // event in
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fwtc_pkg::TIME_W-1:0]       req_time_ms,
   input  logic [fwtc_pkg::TENANT_W-1:0]     req_tenant_index,
   input  logic [fwtc_pkg::ENTITY_W-1:0]     req_entity_index,
   input  logic [fwtc_pkg::TAG_W-1:0]        req_tag_key,
   // verdict out
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_flagged,
   output logic [fwtc_pkg::COUNT_W-1:0]      rsp_win_count,
   output logic [fwtc_pkg::TIME_W-1:0]       rsp_window_number
);
   import fwtc_pkg::*;

   localparam int ADDR_BITS = TENANT_BITS + KEY_BITS;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = '1;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [1:0]         group_mode_ff;
   logic [LEN_W-1:0]   window_length_ff;
   logic [COUNT_W-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_mode_ff    <= GROUP_MODE_RESET;
         window_length_ff <= WINDOW_LENGTH_RESET;
         threshold_ff     <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GROUP_MODE:    group_mode_ff    <= csr_wdata[1:0];
            CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_THRESHOLD:     threshold_ff     <= csr_wdata[COUNT_W-1:0];
            default: ;  // unknown index: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // table index: tenant on top, selected key below
   // group mode 3 falls back to entity
   // ---------------------------------------------------------------
   logic [WIDE_W-1:0]    key_wide;
   logic [WIDE_W-1:0]    tenant_wide;
   logic [ADDR_BITS-1:0] req_addr;

   always_comb begin
      case (group_mode_ff)
         GROUP_TENANT: key_wide = WIDE_W'(req_tenant_index);
         GROUP_TAG:    key_wide = WIDE_W'(req_tag_key);
         default:      key_wide = WIDE_W'(req_entity_index);
      endcase
      tenant_wide = WIDE_W'(req_tenant_index);
      req_addr    = {tenant_wide[TENANT_BITS-1:0], key_wide[KEY_BITS-1:0]};
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   fwtc_state_type       state_ff, state_in;
   logic [ADDR_BITS-1:0] clear_addr_ff, clear_addr_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [TIME_W-1:0]    win_ff, win_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_flagged_ff, rsp_flagged_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [TIME_W-1:0]    rsp_window_ff, rsp_window_in;

   logic                 accept;
   logic                 div_done;
   logic [TIME_W-1:0]    div_quotient;
   fwtc_entry_type       rd_entry;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   fwtc_entry_type       wr_entry;
   logic                 slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // output register can take a new beat when empty or draining now
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      addr_in        = addr_ff;
      win_in         = win_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_flagged_in = rsp_flagged_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_window_in  = rsp_window_ff;
      wr_en          = 1'b0;
      wr_addr        = addr_ff;
      wr_entry       = '{window: win_ff, count: cnt_ff};

      case (state_ff)
         ST_CLEAR: begin
            // sweep the table to window 0 / count 0
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_entry      = '0;
            clear_addr_in = clear_addr_ff + ADDR_BITS'(1);
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // divider start and table read both fire on the accept edge
            if (accept) begin
               addr_in  = req_addr;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            // new window restarts at 1, same window bumps and saturates
            win_in = div_quotient;
            if (rd_entry.window != div_quotient) begin
               cnt_in = COUNT_W'(1);
            end else if (rd_entry.count != COUNT_MAX) begin
               cnt_in = rd_entry.count + COUNT_W'(1);
            end else begin
               cnt_in = rd_entry.count;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // commit and publish together; hold here while the rsp side stalls
            if (slot_free) begin
               wr_en          = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_flagged_in = (cnt_ff > threshold_ff);
               rsp_count_in   = cnt_ff;
               rsp_window_in  = win_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      win_ff         <= win_in;
      cnt_ff         <= cnt_in;
      rsp_flagged_ff <= rsp_flagged_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_window_ff  <= rsp_window_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // window number: time_ms / window_length_ms, serial
   // ---------------------------------------------------------------
   fwtc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_time_ms),
      .divisor  (window_length_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------
   // per-key window/count table
   // ---------------------------------------------------------------
   fwtc_table #(
      .ADDR_BITS (ADDR_BITS)
   ) u_table (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flagged       = rsp_flagged_ff;
   assign rsp_win_count     = rsp_count_ff;
   assign rsp_window_number = rsp_window_ff;

endmodule
